@@ design/spes_pkg.sv @@
// ----------------------------------------------------------------------------
// spes_pkg
// Shared types and constants of the staggered periodic event scheduler:
// transaction payloads, configuration register map, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package spes_pkg;

  // Request codes carried in req_type.
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  // Most results one tick may produce.
  localparam int MAX_RESULTS = 32;
  localparam int RES_W       = 6;

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_FAST_COUNT,
    REG_MEDIUM_COUNT,
    REG_SLOW_COUNT,
    REG_VSLOW_COUNT,
    REG_FAST_PERIOD,
    REG_MEDIUM_PERIOD,
    REG_SLOW_PERIOD,
    REG_VSLOW_PERIOD
  } reg_idx_t;

  // Period reset values, element 0 belongs to group zero.
  localparam logic [3:0][14:0] PERIOD_RST = {15'd5000, 15'd2000, 15'd1000, 15'd75};

  typedef struct packed {
    logic        req_type;
    logic [31:0] now_ms;
    logic [1:0]  group_sel;
    logic [2:0]  slot_sel;
    logic [15:0] slot_delay;
    logic        slot_has_action;
  } in_item_t;

  typedef struct packed {
    logic [1:0] fire_group;
    logic [2:0] fire_slot;
    logic       group_restarted;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [3:0][3:0]  count;
    logic [3:0][14:0] period;
  } cfg_regs_t;

  typedef struct packed {
    logic load_item;
    logic start_tick;
    logic next_group;
    logic rd_slot;
    logic advance;
    logic commit;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic in_is_load;
    logic slot_in_range;
    logic last_group;
    logic fire_hit;
    logic pend_valid;
    logic out_free;
  } st_t;

endpackage

@@ design/spes_cfg.sv @@
// ----------------------------------------------------------------------------
// spes_cfg
// Configuration register file with an APB-style slave port: slot counts and
// base periods of the four rate groups.
// ----------------------------------------------------------------------------
module spes_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spes_pkg::ADDR_W-1:0] paddr,
  input  logic [spes_pkg::DATA_W-1:0] pwdata,
  output logic [spes_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output spes_pkg::cfg_regs_t         regs
);
  import spes_pkg::*;

  logic [3:0][3:0]  count_r;
  logic [3:0][14:0] period_r;
  reg_idx_t         idx;
  logic             wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      period_r <= PERIOD_RST;
    end else if (wr_en) begin
      case (idx)
        REG_FAST_COUNT:    count_r[0]  <= pwdata[3:0];
        REG_MEDIUM_COUNT:  count_r[1]  <= pwdata[3:0];
        REG_SLOW_COUNT:    count_r[2]  <= pwdata[3:0];
        REG_VSLOW_COUNT:   count_r[3]  <= pwdata[3:0];
        REG_FAST_PERIOD:   period_r[0] <= pwdata[14:0];
        REG_MEDIUM_PERIOD: period_r[1] <= pwdata[14:0];
        REG_SLOW_PERIOD:   period_r[2] <= pwdata[14:0];
        REG_VSLOW_PERIOD:  period_r[3] <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FAST_COUNT:    prdata = DATA_W'(count_r[0]);
      REG_MEDIUM_COUNT:  prdata = DATA_W'(count_r[1]);
      REG_SLOW_COUNT:    prdata = DATA_W'(count_r[2]);
      REG_VSLOW_COUNT:   prdata = DATA_W'(count_r[3]);
      REG_FAST_PERIOD:   prdata = DATA_W'(period_r[0]);
      REG_MEDIUM_PERIOD: prdata = DATA_W'(period_r[1]);
      REG_SLOW_PERIOD:   prdata = DATA_W'(period_r[2]);
      REG_VSLOW_PERIOD:  prdata = DATA_W'(period_r[3]);
      default:           prdata = '0;
    endcase
  end

  assign regs.count  = count_r;
  assign regs.period = period_r;

endmodule

@@ design/spes_ctrl.sv @@
// ----------------------------------------------------------------------------
// spes_ctrl
// Controller of the scheduler: accepts transactions, sequences the slot walk
// of a tick and the final flush of the held result.
// ----------------------------------------------------------------------------
module spes_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  spes_pkg::st_t st,
  output spes_pkg::cmd_t cmd
);
  import spes_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FLUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (st.in_is_load) begin
            cmd.load_item = 1'b1;
          end else begin
            cmd.start_tick = 1'b1;
            state_nxt      = S_READ;
          end
        end
      end
      S_READ: begin
        if (st.slot_in_range) begin
          cmd.rd_slot = 1'b1;
          state_nxt   = S_EVAL;
        end else if (st.last_group) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.next_group = 1'b1;
        end
      end
      S_EVAL: begin
        // A firing pushes the previously held result out, so it waits for
        // room in the output register.
        if (st.fire_hit) begin
          if (!st.pend_valid || st.out_free) begin
            cmd.commit = 1'b1;
            state_nxt  = S_READ;
          end
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_FLUSH: begin
        if (!st.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/spes_dp.sv @@
// ----------------------------------------------------------------------------
// spes_dp
// Datapath of the scheduler: slot tables, group start times, walk counters,
// the firing compare, the held result and the output register.
// ----------------------------------------------------------------------------
module spes_dp #(
  parameter int SLOTS  = 8,
  parameter int GROUPS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spes_pkg::in_item_t   in_data,
  input  spes_pkg::cfg_regs_t  regs,
  input  spes_pkg::cmd_t       cmd,
  output spes_pkg::st_t        st,
  output logic                 out_valid,
  input  logic                 out_stall,
  output spes_pkg::out_item_t  out_data
);
  import spes_pkg::*;

  localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // Slot tables.
  logic [15:0]  delay_mem [GROUPS][SLOTS];
  logic         fired_r   [GROUPS][SLOTS];
  logic         act_r     [GROUPS][SLOTS];
  logic [31:0]  start_r   [GROUPS];

  // Walk state.
  logic [31:0]    now_r;
  logic [GW-1:0]  g_r;
  logic [CW-1:0]  s_r;
  logic [RES_W-1:0] n_r;
  logic [31:0]    elapsed_r;
  logic [15:0]    dly_rd_r;

  out_item_t pend_r;
  logic      pend_valid_r;
  out_item_t out_r;
  logic      out_valid_r;

  logic [SW-1:0]    s_idx;
  logic [3:0]       cnt_raw;
  logic [CW-1:0]    cnt_cl;
  logic             last_slot;
  logic [CW:0]      s_plus1;
  logic [16+CW:0]   prod;
  logic [16:0]      thr;
  logic             hit;
  logic             out_free;
  out_item_t        new_res;
  logic             ld_ok;
  logic [GW-1:0]    ld_g;
  logic [SW-1:0]    ld_s;

  assign s_idx   = s_r[SW-1:0];
  assign cnt_raw = regs.count[2'(g_r)];

  // Counts above the capacity are taken as the capacity.
  always_comb begin
    if ({1'b0, cnt_raw} > 5'(SLOTS)) begin
      cnt_cl = CW'(SLOTS);
    end else begin
      cnt_cl = CW'(cnt_raw);
    end
  end

  assign last_slot = (s_r == CW'(cnt_cl - 1'b1));
  assign s_plus1   = {1'b0, s_r} + 1'b1;
  assign prod      = dly_rd_r * s_plus1;
  assign thr       = {2'b0, regs.period[2'(g_r)]} + {1'b0, prod[15:0]};

  assign hit = !fired_r[g_r][s_idx] && act_r[g_r][s_idx] &&
               (elapsed_r > {15'b0, thr}) && (n_r < RES_W'(MAX_RESULTS));

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    new_res.fire_group      = 2'(g_r);
    new_res.fire_slot       = 3'(s_r);
    new_res.group_restarted = last_slot;
    new_res.last            = 1'b0;
  end

  assign ld_ok = ({1'b0, in_data.group_sel} < 3'(GROUPS)) &&
                 ({2'b0, in_data.slot_sel} < 5'(SLOTS));
  assign ld_g  = GW'(in_data.group_sel);
  assign ld_s  = SW'(in_data.slot_sel);

  assign st.in_is_load    = (in_data.req_type == REQ_LOAD);
  assign st.slot_in_range = (s_r < cnt_cl);
  assign st.last_group    = (g_r == GW'(GROUPS - 1));
  assign st.fire_hit      = hit;
  assign st.pend_valid    = pend_valid_r;
  assign st.out_free      = out_free;

  // Delay table: written by loads, read into a register in S_READ ahead of the compare in S_EVAL.
  always_ff @(posedge clk) begin
    if (cmd.load_item && ld_ok) begin
      delay_mem[ld_g][ld_s] <= in_data.slot_delay;
    end
    if (cmd.rd_slot) begin
      dly_rd_r <= delay_mem[g_r][s_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_tick) begin
      now_r <= in_data.now_ms;
    end
    if (cmd.rd_slot) begin
      elapsed_r <= now_r - start_r[g_r];
    end
    if (cmd.commit) begin
      pend_r <= new_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r          <= '0;
      s_r          <= '0;
      n_r          <= '0;
      pend_valid_r <= 1'b0;
      for (int g = 0; g < GROUPS; g++) begin
        start_r[g] <= '0;
        for (int c = 0; c < SLOTS; c++) begin
          fired_r[g][c] <= 1'b0;
          act_r[g][c]   <= 1'b0;
        end
      end
    end else begin
      if (cmd.load_item && ld_ok) begin
        act_r[ld_g][ld_s]   <= in_data.slot_has_action;
        fired_r[ld_g][ld_s] <= 1'b0;
      end
      if (cmd.start_tick) begin
        g_r          <= '0;
        s_r          <= '0;
        n_r          <= '0;
        pend_valid_r <= 1'b0;
      end
      if (cmd.next_group) begin
        g_r <= g_r + 1'b1;
        s_r <= '0;
      end
      if (cmd.advance) begin
        s_r <= s_r + 1'b1;
      end
      if (cmd.commit) begin
        s_r          <= s_r + 1'b1;
        n_r          <= n_r + 1'b1;
        pend_valid_r <= 1'b1;
        // The last slot in use restarts the group: every slot in use is
        // cleared, including the one that just fired.
        if (last_slot) begin
          start_r[g_r] <= now_r;
          for (int c = 0; c < SLOTS; c++) begin
            if (CW'(c) < cnt_cl) begin
              fired_r[g_r][c] <= 1'b0;
            end
          end
        end else begin
          fired_r[g_r][s_idx] <= 1'b1;
        end
      end
      if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  // Output register. A result is held back until the next one is found or
  // the walk ends, so that the final one can carry the last flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.flush) begin
      out_valid_r <= 1'b1;
    end else if (cmd.commit && pend_valid_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush) begin
      out_r <= '{fire_group:      pend_r.fire_group,
                 fire_slot:       pend_r.fire_slot,
                 group_restarted: pend_r.group_restarted,
                 last:            1'b1};
    end else if (cmd.commit && pend_valid_r) begin
      out_r <= pend_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ design/staggered_periodic_event_scheduler.sv @@
// ----------------------------------------------------------------------------
// staggered_periodic_event_scheduler
// Four rate groups of staggered event slots, fired against a millisecond
// time brought by tick transactions.
// ----------------------------------------------------------------------------
// A load transaction writes one slot. A tick transaction walks the slots in
// use of every group through one shared compare, each slot as a delay table
// read, then the threshold compare; a firing waits while the result side
// stalls. Each result is held one firing back so the final one of a tick can
// carry the last flag; input is taken again once the walk and that final
// result have left the walk. The slot tables come out of reset empty and
// need no clearing pass.
module staggered_periodic_event_scheduler #(
  parameter int SLOTS  = 8,
  parameter int GROUPS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  spes_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output spes_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spes_pkg::ADDR_W-1:0] paddr,
  input  logic [spes_pkg::DATA_W-1:0] pwdata,
  output logic [spes_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import spes_pkg::*;

  cfg_regs_t regs;
  cmd_t      cmd;
  st_t       st;

  spes_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  spes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  spes_dp #(
    .SLOTS  (SLOTS),
    .GROUPS (GROUPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .regs      (regs),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ design/spes_chk.sv @@
// ----------------------------------------------------------------------------
// spes_chk
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module spes_chk #(
  parameter int SLOTS  = 8,
  parameter int GROUPS = 4
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input spes_pkg::out_item_t out_data
);
  import spes_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Results only name groups that exist.
  a_group_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_data.fire_group} < 3'(GROUPS)))
    else $error("result names a group beyond the configured groups");

  // Results only name slots that exist.
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((SLOTS > 7) || ({2'b0, out_data.fire_slot} < 5'(SLOTS))))
    else $error("result names a slot beyond the capacity");

  // No result comes out right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind staggered_periodic_event_scheduler spes_chk #(
  .SLOTS  (SLOTS),
  .GROUPS (GROUPS)
) u_spes_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
